FILE: design/ftsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsc_pkg: shared types and constants
// Item payloads, register map and relation codes for the float compaction filter.
// ----------------------------------------------------------------------------
package ftsc_pkg;

    localparam int unsigned MAX_ELEMENTS = 65536;
    localparam int unsigned TOTAL_W      = 17;
    localparam int unsigned PADDR_W      = 3;

    localparam logic [PADDR_W-1:0] ADDR_LIMIT    = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_RELATION = 3'h4;

    localparam logic [2:0] REL_GT = 3'd0;
    localparam logic [2:0] REL_GE = 3'd1;
    localparam logic [2:0] REL_EQ = 3'd2;
    localparam logic [2:0] REL_LE = 3'd3;
    localparam logic [2:0] REL_LT = 3'd4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_ELEMENTS);

    typedef struct packed {
        logic [31:0] lane_a;
        logic [31:0] lane_b;
        logic [31:0] lane_c;
        logic [31:0] lane_d;
        logic        final_group;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        packed_a;
        logic [31:0]        packed_b;
        logic [31:0]        packed_c;
        logic [31:0]        packed_d;
        logic [2:0]         kept_count;
        logic [TOTAL_W-1:0] running_total;
        logic               final_out;
    } out_item_t;

    typedef struct packed {
        logic [31:0] limit_bits;
        logic [2:0]  relation;
    } cfg_t;

    // Order-preserving key for a non-NaN pattern; -0 folds onto +0.
    function automatic logic [31:0] order_key(input logic [31:0] v);
        logic [31:0] w;
        w = (v == 32'h8000_0000) ? 32'h0 : v;
        return w[31] ? ~w : (w | 32'h8000_0000);
    endfunction

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'h0);
    endfunction

endpackage

FILE: design/ftsc_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsc_compare: one lane compare
// Ordered compare of one float pattern against the limit.
// ----------------------------------------------------------------------------
module ftsc_compare (
    input  logic [31:0]   value,
    input  ftsc_pkg::cfg_t cfg,
    output logic          pass
);
    import ftsc_pkg::*;

    logic [31:0] kv;
    logic [31:0] kl;
    logic        hit;

    assign kv = order_key(value);
    assign kl = order_key(cfg.limit_bits);

    always_comb
    begin
        unique case (cfg.relation)
            REL_GT:  hit = kv > kl;
            REL_GE:  hit = kv >= kl;
            REL_EQ:  hit = kv == kl;
            REL_LE:  hit = kv <= kl;
            REL_LT:  hit = kv < kl;
            default: hit = 1'b0;
        endcase
    end

    // drop anything unordered
    assign pass = hit && !is_nan(value) && !is_nan(cfg.limit_bits);

endmodule

FILE: design/ftsc_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsc_pack: lane compaction
// Packs passing lanes to the low end in order and counts them.
// ----------------------------------------------------------------------------
module ftsc_pack (
    input  ftsc_pkg::in_item_t item,
    input  logic [3:0]         pass,
    output logic [31:0]        lanes_out [4],
    output logic [2:0]         count
);
    import ftsc_pkg::*;

    logic [31:0] lanes_in [4];

    assign lanes_in[0] = item.lane_a;
    assign lanes_in[1] = item.lane_b;
    assign lanes_in[2] = item.lane_c;
    assign lanes_in[3] = item.lane_d;

    always_comb
    begin
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            lanes_out[i] = 32'h0;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (pass[i])
            begin
                lanes_out[n[1:0]] = lanes_in[i];
                n = n + 3'd1;
            end
        end
        count = n;
    end

endmodule

FILE: design/float_threshold_stream_compact.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_threshold_stream_compact: float threshold stream compaction
// Keeps the float lanes that meet the limit, packs them low, counts them.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_item_t (four lanes, last mark)
//  out     | output    | out_valid/out_ready| out_item_t (packed lanes, counts)
//  apb     | input     | psel/penable/pready| limit_bits, relation
//
//  One item per cycle while the result register is not held full by out_ready;
//  in_ready follows the result register: it is high whenever the result
//  register is empty or being taken this cycle.
//  Reset clears the config registers, the total and the result valid flag.
// ----------------------------------------------------------------------------
module float_threshold_stream_compact (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ftsc_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ftsc_pkg::out_item_t           out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ftsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ftsc_pkg::*;

    cfg_t               cfg_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W-1:0] sum;
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic [3:0]         pass;
    logic [31:0]        lanes [4];
    logic [2:0]         count;
    logic               take;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr)
            ADDR_LIMIT:    prdata = cfg_reg.limit_bits;
            ADDR_RELATION: prdata = {29'h0, cfg_reg.relation};
            default:       prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            if (paddr == ADDR_LIMIT)
                cfg_reg.limit_bits <= pwdata;
            else if (paddr == ADDR_RELATION)
                cfg_reg.relation <= pwdata[2:0];
        end
    end

    ftsc_compare u_cmp_a (.value(in_item.lane_a), .cfg(cfg_reg), .pass(pass[0]));
    ftsc_compare u_cmp_b (.value(in_item.lane_b), .cfg(cfg_reg), .pass(pass[1]));
    ftsc_compare u_cmp_c (.value(in_item.lane_c), .cfg(cfg_reg), .pass(pass[2]));
    ftsc_compare u_cmp_d (.value(in_item.lane_d), .cfg(cfg_reg), .pass(pass[3]));

    ftsc_pack u_pack (.item(in_item), .pass(pass), .lanes_out(lanes), .count(count));

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // saturate the running total
    assign sum        = total_reg + TOTAL_W'(count);
    assign total_next = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                total_reg     <= in_item.final_group ? '0 : total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.packed_a      <= lanes[0];
            out_reg.packed_b      <= lanes[1];
            out_reg.packed_c      <= lanes[2];
            out_reg.packed_d      <= lanes[3];
            out_reg.kept_count    <= count;
            out_reg.running_total <= total_next;
            out_reg.final_out     <= in_item.final_group;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: verif/tb_float_threshold_stream_compact.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float_threshold_stream_compact: self-checking bench for the float filter
// Drives groups of four floats under several limits and relations, predicts
// the packed lanes, counts and running total, and checks every result item.
// ----------------------------------------------------------------------------
module tb_float_threshold_stream_compact;
    import ftsc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [2:0]  REL_NONE_5  = 3'd5;
    localparam logic [2:0]  REL_NONE_7  = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    float_threshold_stream_compact dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // predictor copy of the registers and the running count
    logic [31:0]        pred_limit = '0;
    logic [2:0]         pred_rel = REL_GT;
    logic [TOTAL_W-1:0] pred_kept = '0;
    out_item_t          expected_q[$];
    int unsigned        mismatches = 0;
    int unsigned        cycles = 0;
    bit                 no_idle = 1'b0;

    function automatic bit nan_bits(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'h0);
    endfunction

    function automatic logic [31:0] sort_key(input logic [31:0] v);
        logic [31:0] w;
        w = (v == 32'h8000_0000) ? 32'h0 : v;
        return w[31] ? ~w : {1'b1, w[30:0]};
    endfunction

    function automatic bit lane_kept(input logic [31:0] v);
        logic [31:0] kv;
        logic [31:0] kl;
        if (nan_bits(v) || nan_bits(pred_limit))
            return 1'b0;
        kv = sort_key(v);
        kl = sort_key(pred_limit);
        case (pred_rel)
            REL_GT: return kv > kl;
            REL_GE: return kv >= kl;
            REL_EQ: return kv == kl;
            REL_LE: return kv <= kl;
            REL_LT: return kv < kl;
            default: return 1'b0;
        endcase
    endfunction

    function automatic out_item_t compact_group(input in_item_t it);
        out_item_t          r;
        logic [31:0]        lanes[4];
        logic [31:0]        kept[4];
        int unsigned        n;
        int unsigned        total;
        lanes[0] = it.lane_a;
        lanes[1] = it.lane_b;
        lanes[2] = it.lane_c;
        lanes[3] = it.lane_d;
        kept = '{default: 32'h0};
        n = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (lane_kept(lanes[i]))
            begin
                kept[n] = lanes[i];
                n++;
            end
        end
        total = pred_kept + n;
        if (total > MAX_ELEMENTS)
            total = MAX_ELEMENTS;
        r.packed_a = kept[0];
        r.packed_b = kept[1];
        r.packed_c = kept[2];
        r.packed_d = kept[3];
        r.kept_count = 3'(n);
        r.running_total = TOTAL_W'(total);
        r.final_out = it.final_group;
        pred_kept = it.final_group ? '0 : TOTAL_W'(total);
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_float_threshold_stream_compact NOT OK");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", out_item);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_item !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h n=%0d t=%0d f=%0b",
                            want.packed_a, want.packed_b, want.packed_c,
                            want.packed_d, want.kept_count, want.running_total,
                            want.final_out, "\n          got %h %h %h %h n=%0d t=%0d f=%0b",
                            out_item.packed_a, out_item.packed_b, out_item.packed_c,
                            out_item.packed_d, out_item.kept_count,
                            out_item.running_total, out_item.final_out);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 17);

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LIMIT)
            pred_limit = data;
        else
            pred_rel = data[2:0];
    endtask

    // drop valid, then wait for every expected item
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] lim, input logic [2:0] rel);
        drain();
        write_reg(ADDR_LIMIT, lim);
        write_reg(ADDR_RELATION, {29'h0, rel});
    endtask

    // call at a falling edge; valid stays high after the accepting edge
    task automatic send_group(input in_item_t it);
        while (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(compact_group(it));
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_float();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            5: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
            6: return pred_limit ^ 32'($urandom_range(1));
            7: return pred_limit;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t random_group(input int unsigned last_pct);
        in_item_t it;
        it.lane_a = pick_float();
        it.lane_b = pick_float();
        it.lane_c = pick_float();
        it.lane_d = pick_float();
        it.final_group = ($urandom_range(99) < last_pct);
        return it;
    endfunction

    task automatic test_directed();
        configure(32'h0000_0000, REL_GT);
        send_group('{32'h3F80_0000, 32'hBF80_0000, 32'h8000_0000, 32'h0000_0001, 1'b0});
        send_group('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7F80_0000, 32'hFF80_0000, 1'b1});
        configure(32'h8000_0000, REL_EQ);
        send_group('{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'h8000_0001, 1'b0});
        configure(32'h7FC0_0000, REL_GE);
        send_group('{32'h0000_0000, 32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 1'b1});
        configure(32'h8000_0001, REL_LE);
        send_group('{32'h8000_0002, 32'h8000_0001, 32'h0000_0000, 32'hFF7F_FFFF, 1'b0});
        configure(32'h7F7F_FFFF, REL_LT);
        send_group('{32'h7F80_0000, 32'h7F7F_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1});
        configure(32'hFFFF_FFFF, REL_NONE_5);
        send_group('{32'h3F80_0000, 32'h0, 32'hBF80_0000, 32'h7F80_0000, 1'b0});
        configure(32'h0000_0000, REL_NONE_7);
        send_group('{32'h3F80_0000, 32'h0, 32'hBF80_0000, 32'h7F80_0000, 1'b1});
        configure(32'hFF80_0000, REL_GE);
        send_group('{32'hFF80_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 1'b0});
        send_group('{32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333, 1'b1});
    endtask

    task automatic test_random_relations();
        logic [2:0] rels[6] = '{REL_GT, REL_GE, REL_EQ, REL_LE, REL_LT, REL_NONE_5};
        for (int p = 0; p < 12; p++)
        begin
            configure((p % 3 == 0) ? pick_float() : $urandom, rels[p % 6]);
            if (p == 4)
                no_idle = 1'b1;
            for (int i = 0; i < 120; i++)
                send_group(random_group(10));
            no_idle = 1'b0;
            if (p == 7)
                drain();
        end
    endtask

    // long array of all-pass groups builds up a large running total
    task automatic test_long_array();
        in_item_t it;
        configure(32'hFF80_0000, REL_GE);
        no_idle = 1'b1;
        for (int i = 0; i < 400; i++)
        begin
            it = random_group(0);
            it.lane_a = 32'h3F80_0000;
            it.lane_b = $urandom & 32'hFF7F_FFFF;
            it.lane_c = 32'h0;
            it.lane_d = 32'h8000_0000;
            it.final_group = (i == 399);
            send_group(it);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_relations();
        test_long_array();
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_float_threshold_stream_compact OK");
        else
            $display("tb_float_threshold_stream_compact NOT OK");
        $finish;
    end

endmodule
